// ===== rtl/adkd_pkg.sv =====
`timescale 1ns / 1ps

package adkd_pkg;

    typedef struct packed {
        logic [15:0] interval_ms;
        logic [9:0]  tolerance;
    } t_cfg;

    typedef logic [2:0] t_key_code;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOLERANCE = 1'd1;

    localparam logic [15:0] INTERVAL_RESET  = 16'd10;
    localparam logic [9:0]  TOLERANCE_RESET = 10'd20;

    localparam int STABLE_RESET   = 950;
    localparam int MATCHES_NEEDED = 2;
    localparam int KEY_STEP       = 100;

    localparam t_key_code KEY_NONE = 3'd0;
    localparam t_key_code KEY_A    = 3'd1;
    localparam t_key_code KEY_B    = 3'd2;
    localparam t_key_code KEY_C    = 3'd3;
    localparam t_key_code KEY_D    = 3'd4;

    // band of the level in steps of one hundred
    function automatic t_key_code decode_key(input logic [31:0] level);
        t_key_code code;
        if (level < 32'(KEY_STEP)) begin
            code = KEY_A;
        end else if (level >= 32'(4 * KEY_STEP) && level < 32'(6 * KEY_STEP)) begin
            code = KEY_B;
        end else if (level >= 32'(6 * KEY_STEP) && level < 32'(7 * KEY_STEP)) begin
            code = KEY_C;
        end else if (level >= 32'(7 * KEY_STEP) && level < 32'(8 * KEY_STEP)) begin
            code = KEY_D;
        end else begin
            code = KEY_NONE;
        end
        return code;
    endfunction

endpackage

// ===== rtl/adkd_core.sv =====
`timescale 1ns / 1ps

module adkd_core #(
    parameter int WINDOW_SAMPLES = 5,
    parameter int ADC_BITS       = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  adkd_pkg::t_cfg      i_cfg,
    input  logic [31:0]         i_now_ms,
    input  logic [ADC_BITS-1:0] i_sample,
    output logic [ADC_BITS-1:0] o_stable_n
);
    import adkd_pkg::*;

    localparam int DW = (ADC_BITS > 10) ? ADC_BITS : 10;
    localparam logic [ADC_BITS-1:0] STABLE_INIT = ADC_BITS'(STABLE_RESET);

    logic [31:0]         r_last;
    logic [2:0]          r_pos;
    logic [2:0]          r_mt;
    logic [ADC_BITS-1:0] r_ref;
    logic [ADC_BITS-1:0] r_stable;

    logic [31:0]         n_last;
    logic [2:0]          n_pos;
    logic [2:0]          n_mt;
    logic [ADC_BITS-1:0] n_ref;
    logic [ADC_BITS-1:0] n_stable;

    logic [31:0]         elapsed;
    logic                take;
    logic [ADC_BITS-1:0] diff;
    logic                match;
    logic [2:0]          pos_inc;
    logic [2:0]          mt_inc;

    always_comb begin
        elapsed = i_now_ms - r_last;
        take    = elapsed > {16'd0, i_cfg.interval_ms};
        n_last  = take ? i_now_ms : r_last;
        n_ref   = (take && r_pos == 3'd0) ? i_sample : r_ref;
        diff    = (i_sample >= n_ref) ? (i_sample - n_ref) : (n_ref - i_sample);
        match   = take && (DW'(diff) < DW'(i_cfg.tolerance));
        pos_inc = take ? (r_pos + 3'd1) : r_pos;
        mt_inc  = match ? (r_mt + 3'd1) : r_mt;
        n_pos    = pos_inc;
        n_mt     = mt_inc;
        n_stable = r_stable;
        // window complete
        if (pos_inc >= 3'(WINDOW_SAMPLES)) begin
            n_pos = 3'd0;
            n_mt  = 3'd0;
            if (mt_inc > 3'(MATCHES_NEEDED)) begin
                n_stable = n_ref;
            end
        end
    end

    assign o_stable_n = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_pos    <= '0;
            r_mt     <= '0;
            r_ref    <= '0;
            r_stable <= STABLE_INIT;
        end else if (i_en) begin
            r_last   <= n_last;
            r_pos    <= n_pos;
            r_mt     <= n_mt;
            r_ref    <= n_ref;
            r_stable <= n_stable;
        end
    end

endmodule

// ===== rtl/adc_key_ladder_debouncer.sv =====
`timescale 1ns / 1ps

// debouncer for an analog keypad read through a resistor ladder
// input channel (i_valid / o_ready): one item is a millisecond timestamp and an
// adc reading; the reading is sampled once the configured interval has passed
// output channel (o_valid / i_ready): one key code per item, in order
// 0 none, 1..4 keys a to d, from the debounced level of the ladder
// path: an accepted item passes the input register, then the window update and
// key decode into the result register, which drives o_valid
// throughput: one item per cycle while the receiver does not stall; the window
// state is updated in the same cycle the item leaves the input register
// a stalled receiver holds the result register; the input register keeps
// accepting until it is full as well, so at most two items are in flight
// configuration: i_cfg_we writes register i_cfg_index at once; index 0 is the
// sample interval, index 1 the match tolerance; write only while idle
// reset (synchronous, active low): interval 10 ms, tolerance 20, stable level
// 950, window and timestamp cleared, both registers empty
module adc_key_ladder_debouncer #(
    parameter int WINDOW_SAMPLES = 5,
    parameter int ADC_BITS       = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [31:0]                       i_now_ms,
    input  logic [9:0]                        i_adc_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output adkd_pkg::t_key_code               o_key_code,
    input  logic                              i_cfg_we,
    input  logic [adkd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adkd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import adkd_pkg::*;

    t_cfg                r_cfg;
    logic                r_in_valid;
    logic [31:0]         r_now;
    logic [ADC_BITS-1:0] r_sample;
    logic                r_out_valid;
    t_key_code           r_key;

    logic                adv;
    logic                step;
    logic [ADC_BITS-1:0] sample_in;
    logic [ADC_BITS-1:0] stable_n;

    generate
        if (ADC_BITS > 10) begin : g_wide
            assign sample_in = {{(ADC_BITS - 10){1'b0}}, i_adc_sample};
        end else begin : g_narrow
            assign sample_in = i_adc_sample[ADC_BITS-1:0];
        end
    endgenerate

    assign adv     = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || adv;
    assign step    = r_in_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval_ms <= INTERVAL_RESET;
            r_cfg.tolerance   <= TOLERANCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_INTERVAL:  r_cfg.interval_ms <= i_cfg_wdata;
                CFG_IDX_TOLERANCE: r_cfg.tolerance   <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_now    <= i_now_ms;
            r_sample <= sample_in;
        end
        if (step) begin
            r_key <= decode_key(32'(stable_n));
        end
    end

    adkd_core #(
        .WINDOW_SAMPLES(WINDOW_SAMPLES),
        .ADC_BITS      (ADC_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (step),
        .i_cfg     (r_cfg),
        .i_now_ms  (r_now),
        .i_sample  (r_sample),
        .o_stable_n(stable_n)
    );

    assign o_valid    = r_out_valid;
    assign o_key_code = r_key;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import adkd_pkg::*;

    localparam int WINDOW_LEN  = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [9:0]  adc;
        logic        typed;
        t_key_code   key;
    } t_row;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [31:0]           i_now_ms     = '0;
    logic [9:0]            i_adc_sample = '0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    t_key_code             o_key_code;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata  = '0;

    // debounce state mirrored from the block
    logic [15:0] cfg_interval  = INTERVAL_RESET;
    logic [9:0]  cfg_tol       = TOLERANCE_RESET;
    logic [31:0] lvl_last_time = '0;
    logic [2:0]  lvl_pos       = '0;
    logic [2:0]  lvl_matches   = '0;
    logic [9:0]  lvl_ref       = '0;
    logic [9:0]  lvl_stable    = 10'(STABLE_RESET);

    t_key_code key_q[$];
    t_row      dir_rows[$];
    t_key_code got_want;
    int        fails         = 0;
    int        cycle_cnt     = 0;
    bit        rst_done      = 1'b0;
    bit        idle_on       = 1'b1;
    bit        long_hold_req = 1'b0;

    adc_key_ladder_debouncer #(
        .WINDOW_SAMPLES(WINDOW_LEN),
        .ADC_BITS      (10)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_now_ms    (i_now_ms),
        .i_adc_sample(i_adc_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_key_code  (o_key_code),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("adc_key_ladder_debouncer test failed");
            $finish;
        end
    end

    function automatic t_key_code band_to_key(input logic [9:0] level);
        t_key_code code;
        case (int'(level) / KEY_STEP)
            0:       code = KEY_A;
            4, 5:    code = KEY_B;
            6:       code = KEY_C;
            7:       code = KEY_D;
            default: code = KEY_NONE;
        endcase
        return code;
    endfunction

    function automatic t_key_code debounce_step(input logic [31:0] now, input logic [9:0] adc);
        logic [31:0] elapsed;
        logic [9:0]  gap;
        elapsed = now - lvl_last_time;
        if (elapsed > {16'd0, cfg_interval}) begin
            lvl_last_time = now;
            if (lvl_pos == 3'd0) begin
                lvl_ref = adc;
            end
            gap = (adc >= lvl_ref) ? adc - lvl_ref : lvl_ref - adc;
            if (gap < cfg_tol) begin
                lvl_matches = lvl_matches + 3'd1;
            end
            lvl_pos = lvl_pos + 3'd1;
        end
        if (int'(lvl_pos) >= WINDOW_LEN) begin
            lvl_pos = 3'd0;
            if (int'(lvl_matches) > MATCHES_NEEDED) begin
                lvl_stable = lvl_ref;
            end
            lvl_matches = 3'd0;
        end
        return band_to_key(lvl_stable);
    endfunction

    task automatic send_item(input logic [31:0] now, input logic [9:0] adc,
                             input logic typed, input t_key_code typed_key);
        t_key_code model_key;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_now_ms     <= now;
        i_adc_sample <= adc;
        do @(posedge i_clk); while (!o_ready);
        model_key = debounce_step(now, adc);
        key_q.push_back(typed ? typed_key : model_key);
    endtask

    task automatic drain_block();
        i_valid <= 1'b0;
        while (key_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] interval, input logic [15:0] tol_word);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_INTERVAL;
        i_cfg_wdata <= interval;
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_TOLERANCE;
        i_cfg_wdata <= tol_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_interval = interval;
        cfg_tol      = tol_word[9:0];
    endtask

    task automatic add_row(input logic [31:0] now, input logic [9:0] adc,
                           input logic typed, input t_key_code key);
        t_row r;
        r.now_ms = now;
        r.adc    = adc;
        r.typed  = typed;
        r.key    = key;
        dir_rows.push_back(r);
    endtask

    task automatic run_phase(input logic [15:0] interval, input logic [15:0] tol_word,
                             input int count, input bit quiet, input bit pressure);
        logic [31:0] now;
        logic [9:0]  adc;
        int          target;
        int          mode;
        int          delta;
        int          level;
        int          k;
        int          levels[8];
        levels = '{40, 450, 560, 650, 750, 150, 850, 1010};
        target = 450;
        drain_block();
        set_config(interval, tol_word);
        idle_on = !quiet;
        if (pressure) begin
            long_hold_req = 1'b1;
        end
        for (k = 0; k < count; k++) begin
            if (pressure && k == count / 2) begin
                drain_block();
            end
            if (lvl_pos == 3'd0 && $urandom_range(0, 1) == 0) begin
                target = ($urandom_range(0, 9) < 3) ? int'($urandom_range(0, 1023))
                                                    : levels[$urandom_range(0, 7)];
            end
            delta = $urandom_range(0, int'(cfg_tol));
            level = ($urandom_range(0, 1) == 0) ? target + delta : target - delta;
            if (level < 0) level = 0;
            if (level > 1023) level = 1023;
            adc  = 10'(level);
            mode = $urandom_range(0, 99);
            if (mode < 70) begin
                now = lvl_last_time + {16'd0, cfg_interval} + 32'd1 + $urandom_range(0, 3);
                if ($urandom_range(0, 99) < 15) begin
                    adc = 10'($urandom);
                end
            end else if (mode < 85) begin
                now = lvl_last_time + $urandom_range(0, int'(cfg_interval));
                adc = 10'($urandom);
            end else if (mode < 90) begin
                // right at the interval, taken only one millisecond later
                now = lvl_last_time + {16'd0, cfg_interval} + $urandom_range(0, 1);
            end else begin
                now = $urandom;
                adc = 10'($urandom);
            end
            send_item(now, adc, 1'b0, KEY_NONE);
        end
    endtask

    initial begin : receiver
        int hold;
        wait (rst_done);
        forever begin
            if (long_hold_req) begin
                i_ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (key_q.size() == 0) begin
                if (fails < MAX_REPORTS)
                    $display("%0t: key code expected none actual %0d", $time, o_key_code);
                fails++;
            end else begin
                got_want = key_q.pop_front();
                if (o_key_code !== got_want) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t: key code expected %0d actual %0d",
                                 $time, got_want, o_key_code);
                    fails++;
                end
            end
        end
    end

    initial begin : stimulus
        int i;
        // reset level reads as no key until a window completes
        add_row(32'd0,          10'd0,    1'b1, KEY_NONE);
        add_row(32'd10,         10'd1023, 1'b1, KEY_NONE);
        add_row(32'd11,         10'd50,   1'b1, KEY_NONE);
        add_row(32'd22,         10'd69,   1'b1, KEY_NONE);
        add_row(32'd33,         10'd70,   1'b1, KEY_NONE);
        add_row(32'd44,         10'd1023, 1'b0, KEY_NONE);
        add_row(32'd55,         10'd31,   1'b0, KEY_NONE);
        add_row(32'd66,         10'd450,  1'b0, KEY_NONE);
        add_row(32'd77,         10'd455,  1'b0, KEY_NONE);
        add_row(32'd80,         10'd0,    1'b0, KEY_NONE);
        add_row(32'd88,         10'd445,  1'b0, KEY_NONE);
        add_row(32'd99,         10'd460,  1'b0, KEY_NONE);
        add_row(32'd110,        10'd999,  1'b0, KEY_NONE);
        // timestamp going backwards
        add_row(32'd5,          10'd650,  1'b0, KEY_NONE);
        add_row(32'd16,         10'd655,  1'b0, KEY_NONE);
        add_row(32'd27,         10'd640,  1'b0, KEY_NONE);
        add_row(32'd38,         10'd0,    1'b0, KEY_NONE);
        add_row(32'd49,         10'd0,    1'b0, KEY_NONE);
        // window across the timestamp wrap
        add_row(32'hFFFF_FFF0,  10'd750,  1'b0, KEY_NONE);
        add_row(32'hFFFF_FFFF,  10'd760,  1'b0, KEY_NONE);
        add_row(32'h0000_000A,  10'd745,  1'b0, KEY_NONE);
        add_row(32'h0000_0015,  10'd751,  1'b0, KEY_NONE);
        add_row(32'h0000_0020,  10'd700,  1'b0, KEY_NONE);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        for (i = 0; i < dir_rows.size(); i++) begin
            send_item(dir_rows[i].now_ms, dir_rows[i].adc, dir_rows[i].typed, dir_rows[i].key);
        end

        run_phase(16'd10,    16'd20,   250, 1'b0, 1'b0);
        run_phase(16'd0,     16'd0,    150, 1'b0, 1'b0);
        run_phase(16'hFFFF,  16'd1023, 150, 1'b0, 1'b0);
        run_phase(16'd0,     16'd1023, 150, 1'b0, 1'b0);
        run_phase(16'd3,     16'd25,   250, 1'b0, 1'b1);
        repeat (3) begin
            run_phase(16'($urandom_range(0, 40)),
                      {6'($urandom), 10'($urandom_range(1, 60))}, 150, 1'b0, 1'b0);
        end
        run_phase(16'd10,    16'd20,   200, 1'b1, 1'b0);

        i_valid <= 1'b0;
        while (key_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fails == 0) begin
            $display("adc_key_ladder_debouncer test passed");
        end else begin
            $display("adc_key_ladder_debouncer test failed");
        end
        $finish;
    end

endmodule
